// ===== design/rrtu_pkg.sv =====
// Package for the route table update block: default sizes, status codes, cell entry type.
// No dependencies.
package rrtu_pkg;
  localparam int TableDepthDef = 16;
  localparam int PortCountDef  = 8;
  localparam logic [4:0] MetricInf = 5'd16;

  localparam logic [2:0] StIgnored   = 3'd0;
  localparam logic [2:0] StAdded     = 3'd1;
  localparam logic [2:0] StRefreshed = 3'd2;
  localparam logic [2:0] StReplaced  = 3'd3;
  localparam logic [2:0] StNotTaken  = 3'd4;
  localparam logic [2:0] StFull      = 3'd5;
  localparam logic [2:0] StDump      = 3'd6;
  localparam logic [2:0] StDumpEmpty = 3'd7;

  // entry carried along the cell chain
  typedef struct packed {
    logic        vld;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [4:0]  metric;
    logic [2:0]  port;
  } entry_t;
endpackage

// ===== design/rrtu_cell.sv =====
// One table slot of the rotating chain: holds one entry, passes it on when shifting.
// Depends on rrtu_pkg.
module rrtu_cell
  import rrtu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  logic   load,
  input  entry_t load_val,
  input  entry_t prev,
  output entry_t cur
);
  entry_t cur_r, cur_nxt;
  always_comb begin
    cur_nxt = cur_r;
    if (load) begin
      cur_nxt = load_val;
    end else if (shift) begin
      cur_nxt = prev;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
    end else begin
      cur_r.vld <= cur_nxt.vld;
    end
    cur_r.dest   <= cur_nxt.dest;
    cur_r.mask   <= cur_nxt.mask;
    cur_r.gw     <= cur_nxt.gw;
    cur_r.metric <= cur_nxt.metric;
    cur_r.port   <= cur_nxt.port;
  end
  assign cur = cur_r;
endmodule

// ===== design/rip_route_table_update.sv =====
// Top level of the route table update block: control, config registers, cell ring.
// Depends on rrtu_pkg and rrtu_cell.
//
// channel | dir | handshake        | contents
// in_     | in  | tvalid/tready    | one route entry or table request
// out_    | out | tvalid/tready    | one result per transfer, tlast ends the item
// cfg_    | in  | APB psel/penable | family and tag match registers
//
// The table is a ring of TABLE_DEPTH cells that rotates one place a cycle during
// a scan. An item rotates the ring through all TABLE_DEPTH slots, inspecting
// slot 0's cell at each step, then makes its decision. A route entry is accepted
// again only once its result is taken and the slot write is done; a rejected
// entry or request gets its result straight from idle, with no scan. A dump
// holds each valid entry until the next one passes (so the last one can carry
// tlast); stalls on out_tready halt the ring and lengthen the item.
// rst_n clears control and all valid bits; entry payload is left unreset.
module rip_route_table_update
  import rrtu_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int PORT_COUNT  = PortCountDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata low->high: dest_ip, net_mask, next_hop, hop_metric, sender_ip,
  // port_id, addr_family, route_tag (168 bits)
  input  logic [167:0] in_tdata,
  input  logic         in_tuser,  // func
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata low->high: status, slot, changed, out_dest, out_mask, out_metric
  output logic [79:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [1:0] SIdle = 2'd0, SScan = 2'd1, SDecide = 2'd2, SOut = 2'd3;

  logic [15:0] fam_r, tag_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fam_r <= 16'd2;
      tag_r <= 16'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == 3'd0) fam_r <= cfg_pwdata[15:0];
      if (cfg_paddr == 3'd4) tag_r <= cfg_pwdata[15:0];
    end
  end
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr == 3'd0) cfg_prdata = {16'd0, fam_r};
    if (cfg_paddr == 3'd4) cfg_prdata = {16'd0, tag_r};
  end

  // input fields
  wire [31:0] f_dest   = in_tdata[31:0];
  wire [31:0] f_mask   = in_tdata[63:32];
  wire [31:0] f_hop    = in_tdata[95:64];
  wire [4:0]  f_metric = in_tdata[100:96];
  wire [31:0] f_sender = in_tdata[132:101];
  wire [2:0]  f_port   = in_tdata[135:133];
  wire [15:0] f_family = in_tdata[151:136];
  wire [15:0] f_tag    = in_tdata[167:152];

  logic [1:0]  st_r;
  logic        dump_r, any_r;
  logic [31:0] dest_r, mask_r, gw_r;
  logic [4:0]  met_r;
  logic [2:0]  port_r;
  logic [CW-1:0] cnt_r;     // rotation step, equals slot index at cell 0
  logic          mfound_r, ffound_r;
  logic [IW-1:0] midx_r, fidx_r;
  entry_t        mval_r;
  logic [2:0]  o_st_r;
  logic [3:0]  o_slot_r;
  logic        o_chg_r, o_last_r, ov_r;
  logic [31:0] o_dest_r, o_mask_r;
  logic [4:0]  o_met_r;
  logic        wr_r;        // pending write at slot widx_r
  logic [IW-1:0] widx_r;
  entry_t      wval_r;

  entry_t cell_q [TABLE_DEPTH];
  logic   shift;
  logic   scan_go;
  entry_t head;
  assign head = cell_q[0];
  logic [IW-1:0] cur_idx;
  assign cur_idx = cnt_r[IW-1:0];

  // a held dump result goes out only when the next valid entry replaces it
  assign scan_go = (st_r == SScan) &&
                   (!dump_r || !ov_r || !head.vld || out_tready);
  assign shift   = scan_go;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      // during a scan cell 0 holds slot cnt_r; ring: each takes from its upper neighbor
      rrtu_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .load(wr_r && (st_r == SIdle) && (widx_r == IW'(g))),
        .load_val(wval_r),
        .prev(cell_q[(g + 1) % TABLE_DEPTH]),
        .cur(cell_q[g])
      );
    end
  endgenerate

  assign in_tready = (st_r == SIdle) && !ov_r && !wr_r;
  wire in_go = in_tvalid && in_tready;
  wire out_go = out_tvalid && out_tready;
  wire dump_load = scan_go && dump_r && head.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SIdle;
      ov_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (out_go && !dump_load) ov_r <= 1'b0;
      if (wr_r && st_r == SIdle) wr_r <= 1'b0;
      case (st_r)
        SIdle: begin
          if (in_go) begin
            cnt_r <= '0; mfound_r <= 1'b0; ffound_r <= 1'b0; any_r <= 1'b0;
            midx_r <= '0; fidx_r <= '0;
            dest_r <= f_dest; mask_r <= f_mask; port_r <= f_port;
            gw_r <= (f_hop == 32'd0) ? f_sender : f_hop;
            met_r <= (f_metric >= MetricInf) ? MetricInf : f_metric + 5'd1;
            dump_r <= in_tuser;
            if (in_tuser) begin
              if (f_family != 16'd0 || f_metric != MetricInf) begin
                ov_r <= 1'b1; o_st_r <= StIgnored; o_slot_r <= '0; o_chg_r <= 1'b0;
                o_dest_r <= '0; o_mask_r <= '0; o_met_r <= '0; o_last_r <= 1'b1;
              end else begin
                st_r <= SScan;
              end
            end else if (f_family != fam_r || f_tag != tag_r ||
                         32'(f_port) >= PORT_COUNT) begin
              ov_r <= 1'b1; o_st_r <= StIgnored; o_slot_r <= '0; o_chg_r <= 1'b0;
              o_dest_r <= '0; o_mask_r <= '0; o_met_r <= '0; o_last_r <= 1'b1;
            end else begin
              st_r <= SScan;
            end
          end
        end
        SScan: begin
          if (scan_go) begin
            cnt_r <= cnt_r + CW'(1);
            if (dump_r) begin
              if (head.vld) begin
                any_r <= 1'b1;
                ov_r <= 1'b1; o_st_r <= StDump; o_slot_r <= 4'(cur_idx);
                o_chg_r <= 1'b0; o_dest_r <= head.dest; o_mask_r <= head.mask;
                o_met_r <= head.metric; o_last_r <= 1'b0;
              end
            end else if (head.vld) begin
              if (!mfound_r && head.dest == dest_r) begin
                mfound_r <= 1'b1; midx_r <= cur_idx; mval_r <= head;
              end
            end else if (!ffound_r) begin
              ffound_r <= 1'b1; fidx_r <= cur_idx;
            end
            if (cnt_r == CW'(TABLE_DEPTH - 1)) st_r <= SDecide;
          end
        end
        SDecide: begin
          // dump tail: mark last on pending output, or report empty
          if (dump_r) begin
            if (!ov_r || out_tready) begin
              if (!any_r) begin
                ov_r <= 1'b1; o_st_r <= StDumpEmpty; o_slot_r <= '0; o_chg_r <= 1'b0;
                o_dest_r <= '0; o_mask_r <= '0; o_met_r <= '0; o_last_r <= 1'b1;
                st_r <= SIdle;
              end else begin
                st_r <= SIdle;
              end
            end
          end else if (!ov_r) begin
            ov_r <= 1'b1; o_last_r <= 1'b1; o_chg_r <= 1'b0;
            o_dest_r <= '0; o_mask_r <= '0; o_met_r <= '0; o_slot_r <= '0;
            st_r <= SIdle;
            if (!mfound_r) begin
              if (!ffound_r) o_st_r <= StFull;
              else if (met_r >= MetricInf) o_st_r <= StNotTaken;
              else begin
                o_st_r <= StAdded; o_slot_r <= 4'(fidx_r); o_chg_r <= 1'b1;
                o_dest_r <= dest_r; o_mask_r <= mask_r; o_met_r <= met_r;
                wr_r <= 1'b1; widx_r <= fidx_r;
                wval_r <= '{vld: 1'b1, dest: dest_r, mask: mask_r, gw: gw_r,
                            metric: met_r, port: port_r};
              end
            end else if (mval_r.gw == gw_r) begin
              o_st_r <= StRefreshed; o_slot_r <= 4'(midx_r);
              o_chg_r <= (mval_r.metric != met_r);
              o_dest_r <= dest_r; o_mask_r <= mask_r;
              wr_r <= 1'b1; widx_r <= midx_r;
              if (mval_r.metric < MetricInf || met_r < MetricInf) begin
                o_met_r <= met_r;
                wval_r <= '{vld: 1'b1, dest: dest_r, mask: mask_r, gw: gw_r,
                            metric: met_r, port: port_r};
              end else begin
                o_met_r <= mval_r.metric;
                wval_r <= '{vld: 1'b1, dest: dest_r, mask: mask_r, gw: gw_r,
                            metric: mval_r.metric, port: port_r};
              end
            end else if (mval_r.metric > met_r) begin
              o_st_r <= StReplaced; o_slot_r <= 4'(midx_r); o_chg_r <= 1'b1;
              o_dest_r <= dest_r; o_mask_r <= mask_r; o_met_r <= met_r;
              wr_r <= 1'b1; widx_r <= midx_r;
              wval_r <= '{vld: 1'b1, dest: dest_r, mask: mask_r, gw: gw_r,
                          metric: met_r, port: port_r};
            end else begin
              o_st_r <= StNotTaken; o_slot_r <= 4'(midx_r);
            end
          end
        end
        default: st_r <= SIdle;
      endcase
    end
  end

  // during a dump scan the held result is shown only once a later valid entry
  // is at cell 0; the final one waits for the decide stage, which adds tlast
  logic hold_out;
  assign hold_out = dump_r && (st_r == SScan) && !head.vld;
  assign out_tvalid = ov_r && !hold_out;
  assign out_tlast  = o_last_r || (dump_r && st_r == SDecide && any_r);
  assign out_tdata  = {3'b000, o_met_r, o_mask_r, o_dest_r, o_chg_r, o_slot_r, o_st_r};
endmodule
